/* hdl/bba_pkg.sv */
// Shared types and constants for the buddy block allocator.
// Depends on nothing; the allocator, its checker, the scoreboard and the testbench import it.
package bba_pkg;

    // Command codes carried in the request word.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_DEALLOC = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Per-node state codes held in the tree memory.
    localparam logic [1:0] NODE_FREE  = 2'd0;
    localparam logic [1:0] NODE_SPLIT = 2'd1;
    localparam logic [1:0] NODE_ALLOC = 2'd2;

    // One request word.
    typedef struct packed {
        logic        command;
        logic [15:0] request_size;
    } t_req;

    // One result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] rounded_size;
    } t_rsp;

endpackage

/* hdl/bba_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/buddy_block_allocator.sv */
// Buddy block allocator without merging. The node states of the whole tree (2*R
// entries, R the largest power of two not above TOTAL_SIZE) live in one RAM with a
// registered read. After reset a clearing pass writes every node free; no request
// is taken meanwhile. Each node visit takes a read state, then a check-and-write
// state. An allocate walks the tree depth first, skipping allocated subtrees, then
// walks the ancestors of the chosen node back to the root, and the result state
// follows. A deallocate scans the level of the rounded size left to right.
// Out-of-range sizes go straight to the result state. One request is in work at a
// time; the result waits in an output register while the next request is taken.
module buddy_block_allocator #(
    parameter int TOTAL_SIZE = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bba_pkg::t_req   i_in_word,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bba_pkg::t_rsp   o_out_word
);
    import bba_pkg::*;

    localparam int LG_R = $clog2(TOTAL_SIZE + 1) - 1;
    localparam int NW   = LG_R + 1;
    localparam int DEPTH = 2 ** NW;

    typedef enum logic [6:0] {
        S_CLR   = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_UPRD  = 7'b0010000,
        S_UPCHK = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [NW-1:0] r_clr, n_clr;
    logic [NW-1:0] r_node, n_node;
    logic [NW-1:0] r_first, n_first;
    logic          r_cmd, n_cmd;
    logic [1:0]    r_status, n_status;
    logic [16:0]   r_rounded, n_rounded;
    logic          r_ovalid, n_ovalid;
    t_rsp          r_out, n_out;

    logic          we;
    logic [NW-1:0] waddr;
    logic [1:0]    wdata;
    logic [1:0]    rdata;

    logic [15:0]   req_m1;
    logic [4:0]    lg;
    logic          bad;
    logic [NW:0]   nx;
    logic [4:0]    tz;
    logic          out_free;

    bba_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_node),
        .o_rdata (rdata)
    );

    // Round the request up: log2 is one more than the top set bit of size-1.
    always_comb begin
        req_m1 = i_in_word.request_size - 16'd1;
        lg = 5'd0;
        if (i_in_word.request_size > 16'd1) begin
            for (int b = 0; b < 16; b++) begin
                if (req_m1[b]) begin
                    lg = 5'(b + 1);
                end
            end
        end
        bad = (i_in_word.request_size == 16'd0) ||
              ({1'b0, i_in_word.request_size} > 17'(TOTAL_SIZE));
    end

    // Next node in depth-first order after skipping the current subtree.
    always_comb begin
        nx = {1'b0, r_node} + (NW+1)'(1);
        tz = 5'd0;
        for (int b = NW; b >= 0; b--) begin
            if (nx[b]) begin
                tz = 5'(b);
            end
        end
    end

    assign out_free = !r_ovalid || !i_out_stall;

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_node    = r_node;
        n_first   = r_first;
        n_cmd     = r_cmd;
        n_status  = r_status;
        n_rounded = r_rounded;
        n_ovalid  = r_ovalid && i_out_stall;
        n_out     = r_out;
        we        = 1'b0;
        waddr     = r_node;
        wdata     = NODE_FREE;
        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + NW'(1);
                if (r_clr == NW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_word.command;
                    if (bad) begin
                        n_status  = ST_RANGE;
                        n_rounded = 17'd0;
                        n_state   = S_FIN;
                    end else if (32'(lg) > LG_R) begin
                        n_status  = ST_NONE;
                        n_rounded = 17'd1 << lg;
                        n_state   = S_FIN;
                    end else begin
                        n_rounded = 17'd1 << lg;
                        n_first   = NW'(1) << (5'(LG_R) - lg);
                        n_node    = (i_in_word.command == CMD_DEALLOC)
                                    ? (NW'(1) << (5'(LG_R) - lg)) : NW'(1);
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_cmd == CMD_DEALLOC) begin
                    // Linear scan of one level for the first allocated node.
                    if (rdata == NODE_ALLOC) begin
                        we       = 1'b1;
                        wdata    = NODE_FREE;
                        n_status = ST_DONE;
                        n_state  = S_FIN;
                    end else if (nx == ({1'b0, r_first} << 1)) begin
                        n_status = ST_NONE;
                        n_state  = S_FIN;
                    end else begin
                        n_node  = NW'(nx);
                        n_state = S_RD;
                    end
                end else if (r_node >= r_first && rdata == NODE_FREE) begin
                    // Take this node, then mark the free ancestors as split.
                    we    = 1'b1;
                    wdata = NODE_ALLOC;
                    if ((r_node >> 1) == NW'(0)) begin
                        n_status = ST_DONE;
                        n_state  = S_FIN;
                    end else begin
                        n_node  = r_node >> 1;
                        n_state = S_UPRD;
                    end
                end else if (r_node < r_first && rdata != NODE_ALLOC) begin
                    n_node  = r_node << 1;
                    n_state = S_RD;
                end else if ((nx & (nx - (NW+1)'(1))) == '0) begin
                    // Skipped past the rightmost node: nothing fits.
                    n_status = ST_NONE;
                    n_state  = S_FIN;
                end else begin
                    n_node  = NW'(nx >> tz);
                    n_state = S_RD;
                end
            end
            S_UPRD: begin
                n_state = S_UPCHK;
            end
            S_UPCHK: begin
                if (rdata == NODE_FREE) begin
                    we    = 1'b1;
                    wdata = NODE_SPLIT;
                end
                if ((r_node >> 1) == NW'(0)) begin
                    n_status = ST_DONE;
                    n_state  = S_FIN;
                end else begin
                    n_node  = r_node >> 1;
                    n_state = S_UPRD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid           = 1'b1;
                    n_out.status       = r_status;
                    n_out.rounded_size = r_rounded;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_first   <= n_first;
        r_cmd     <= n_cmd;
        r_status  <= n_status;
        r_rounded <= n_rounded;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

endmodule

/* hdl/bba_checker.sv */
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on bba_pkg.
module bba_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input bba_pkg::t_req i_in_word,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bba_pkg::t_rsp o_out_word
);
    import bba_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed under stall");

    // An out-of-range result carries no rounded size.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_RANGE |-> o_out_word.rounded_size == 17'd0)
        else $error("range error with nonzero size");

    // Any other result carries a power of two.
    a_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_DONE || o_out_word.status == ST_NONE)
        |-> $onehot(o_out_word.rounded_size))
        else $error("rounded size not a power of two");

    // One request in work at a time.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

/* test/bba_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the buddy block allocator: watches both word channels and checks results.
// Depends on bba_pkg for the request and result word types and the status and node codes.
module bba_scoreboard #(
    parameter int TOTAL_SIZE = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  bba_pkg::t_req   i_in_word,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  bba_pkg::t_rsp   i_out_word,
    output int              o_errors,
    output int              o_pending
);
    import bba_pkg::*;

    // Root block size: the largest power of two not above TOTAL_SIZE.
    function automatic int root_size();
        int r;
        r = 1;
        while ((r << 1) <= TOTAL_SIZE) r = r << 1;
        return r;
    endfunction

    localparam int ROOT = root_size();

    logic [1:0] tree_nodes [1:2*ROOT-1];
    t_rsp       pending_results [$];

    // Index of the first node on the level whose blocks hold blk units.
    function automatic int level_first(input int blk);
        int first;
        int sz;
        first = 1;
        sz = ROOT;
        while (sz > blk) begin
            sz = sz >> 1;
            first = first << 1;
        end
        return first;
    endfunction

    // True when some ancestor of the node is allocated whole.
    function automatic bit under_alloc(input int idx);
        int a;
        a = idx >> 1;
        while (a != 0) begin
            if (tree_nodes[a] == NODE_ALLOC) return 1'b1;
            a = a >> 1;
        end
        return 1'b0;
    endfunction

    // Take the leftmost free node of the level with no allocated ancestor and mark free ancestors as split.
    function automatic bit take_block(input int blk);
        int first;
        int a;
        first = level_first(blk);
        for (int i = first; i < 2 * first; i++) begin
            if (tree_nodes[i] == NODE_FREE && !under_alloc(i)) begin
                tree_nodes[i] = NODE_ALLOC;
                a = i >> 1;
                while (a != 0) begin
                    if (tree_nodes[a] == NODE_FREE) tree_nodes[a] = NODE_SPLIT;
                    a = a >> 1;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Free the leftmost allocated node of the level.
    function automatic bit give_block(input int blk);
        int first;
        first = level_first(blk);
        for (int i = first; i < 2 * first; i++) begin
            if (tree_nodes[i] == NODE_ALLOC) begin
                tree_nodes[i] = NODE_FREE;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the result of one request and update the tree copy.
    function automatic t_rsp allocator_step(input t_req w);
        t_rsp r;
        int   blk;
        int   req;
        bit   ok;
        req = int'(w.request_size);
        r.status = ST_DONE;
        r.rounded_size = '0;
        if (req == 0 || req > TOTAL_SIZE) begin
            r.status = ST_RANGE;
        end else begin
            blk = 1;
            while (blk < req) blk = blk << 1;
            r.rounded_size = 17'(blk);
            if (blk > ROOT) begin
                r.status = ST_NONE;
            end else begin
                ok = (w.command == CMD_ALLOC) ? take_block(blk) : give_block(blk);
                r.status = ok ? ST_DONE : ST_NONE;
            end
        end
        return r;
    endfunction

    assign o_pending = pending_results.size();

    // Predict on each accepted request word, then compare each accepted result word.
    always @(posedge i_clk) begin
        t_rsp exp_w;
        int   errs;
        errs = o_errors;
        if (!i_rst_n) begin
            for (int i = 1; i < 2 * ROOT; i++) tree_nodes[i] = NODE_FREE;
            pending_results.delete();
            o_errors <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) pending_results.push_back(allocator_step(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no request pending: status %0d size %0d",
                           i_out_word.status, i_out_word.rounded_size);
                    errs = errs + 1;
                end else begin
                    exp_w = pending_results.pop_front();
                    if (i_out_word.status !== exp_w.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_w.status, i_out_word.status);
                        errs = errs + 1;
                    end
                    if (i_out_word.rounded_size !== exp_w.rounded_size) begin
                        $error("rounded_size: expected %0d, actual %0d",
                               exp_w.rounded_size, i_out_word.rounded_size);
                        errs = errs + 1;
                    end
                end
            end
            o_errors <= errs;
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Top of the buddy block allocator testbench: clock, reset, request stimulus and verdict.
// Depends on bba_pkg, buddy_block_allocator and the bba_scoreboard checker.
module tb;
    import bba_pkg::*;

    localparam int TOTAL_SIZE = 1024;
    localparam int RANDOM_WORDS = 1780;
    localparam int CYCLE_LIMIT = 40000000;

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    logic  in_stall;
    t_req  in_word;
    logic  out_valid;
    logic  out_stall;
    t_rsp  out_word;
    int    errors;
    int    pending;
    int    send_idle;
    int    recv_idle;
    int    sent_words;
    int    cycles;

    buddy_block_allocator #(.TOTAL_SIZE(TOTAL_SIZE)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    bba_scoreboard #(.TOTAL_SIZE(TOTAL_SIZE)) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stalls at random with the current phase's rate.
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one request word, idling first at random; returns once it is accepted.
    task automatic send_word(input logic cmd, input int size);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word.command <= cmd;
        in_word.request_size <= 16'(size);
        do @(posedge i_clk); while (in_stall);
        sent_words++;
    endtask

    // Random request: mostly well-formed sizes biased toward small blocks, some out of range.
    task automatic send_random();
        int   pick;
        int   band;
        int   size;
        logic cmd;
        pick = $urandom_range(99);
        cmd = ($urandom_range(99) < 55) ? CMD_ALLOC : CMD_DEALLOC;
        if (pick < 4) begin
            size = 0;
        end else if (pick < 9) begin
            size = $urandom_range(65535, TOTAL_SIZE + 1);
        end else begin
            band = $urandom_range(10);
            if ($urandom_range(1)) band = $urandom_range(band);
            size = (band == 0) ? 1 : $urandom_range(1 << band, (1 << (band - 1)) + 1);
        end
        send_word(cmd, size);
    endtask

    initial begin
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        i_rst_n = 1'b0;
        cycles = 0;
        sent_words = 0;
        send_idle = 25;
        recv_idle = 78;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: whole pool, splitting, exact-size split nodes, range limits, empty frees.
        send_word(CMD_ALLOC, TOTAL_SIZE);
        send_word(CMD_ALLOC, 1);
        send_word(CMD_DEALLOC, TOTAL_SIZE);
        send_word(CMD_ALLOC, 1);
        send_word(CMD_ALLOC, 1);
        send_word(CMD_ALLOC, TOTAL_SIZE);
        send_word(CMD_ALLOC, 2);
        send_word(CMD_DEALLOC, 2);
        send_word(CMD_ALLOC, 2);
        send_word(CMD_DEALLOC, 8);
        send_word(CMD_ALLOC, 0);
        send_word(CMD_DEALLOC, 0);
        send_word(CMD_ALLOC, TOTAL_SIZE + 1);
        send_word(CMD_DEALLOC, 65535);
        send_word(CMD_ALLOC, 32768);
        send_word(CMD_ALLOC, 16'h5555);
        send_word(CMD_DEALLOC, 16'h2AA);
        send_word(CMD_ALLOC, 3);
        send_word(CMD_ALLOC, 513);
        send_word(CMD_DEALLOC, 1);
        send_word(CMD_DEALLOC, 1);
        send_word(CMD_DEALLOC, 4);
        send_word(CMD_DEALLOC, 512);

        // Random traffic over three pacing phases.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                send_idle = 78;
                recv_idle = 25;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_random();
        end
        in_valid <= 1'b0;

        // Drain, then allow the output register to settle.
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d request words: allocates and frees of every block size,", sent_words);
        $display("out-of-range sizes, and three sender/receiver pacing mixes.");
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
